// ===== rtl/core/imu_complementary_filter_dead_reckoning_macros.svh =====
// Assertion macros shared by the RTL of the IMU attitude and dead-reckoning block.
`ifndef IMU_COMPLEMENTARY_FILTER_DEAD_RECKONING_MACROS_SVH
`define IMU_COMPLEMENTARY_FILTER_DEAD_RECKONING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMUCF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imucf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IMUCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imucf: next-cycle check failed");

`endif

// ===== rtl/core/imucf_pkg.sv =====
package imucf_pkg;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_BLEND_WEIGHT  = 2'd1;
  localparam logic [1:0] REG_GRAVITY       = 2'd2;

  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;
  localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd64225;
  localparam logic [19:0] GRAVITY_RST       = 20'd642689;

  localparam int CORDIC_STEPS = 24;
  localparam int MOD_LAST     = 13;

  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic [45:0]        TWO_PI_M    = 46'd6746518852;

  localparam logic [5:0] LEN_DT    = 6'd17;
  localparam logic [5:0] LEN_ALPHA = 6'd17;
  localparam logic [5:0] LEN_BETA  = 6'd18;
  localparam logic [5:0] LEN_GAIN  = 6'd31;
  localparam logic [5:0] LEN_GRAV  = 6'd21;
  localparam logic [5:0] LEN_TRIG  = 6'd34;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_MUL   = 6'b000100,
    S_CORD  = 6'b001000,
    S_MOD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef enum logic [4:0] {
    P_YAW   = 5'd0,
    P_VEC1  = 5'd1,
    P_MAG   = 5'd2,
    P_VEC2  = 5'd3,
    P_RX    = 5'd4,
    P_GR    = 5'd5,
    P_AR    = 5'd6,
    P_RY    = 5'd7,
    P_GP    = 5'd8,
    P_AP    = 5'd9,
    P_MODR  = 5'd10,
    P_WRR   = 5'd11,
    P_ROTR  = 5'd12,
    P_MODP  = 5'd13,
    P_WRP   = 5'd14,
    P_ROTP  = 5'd15,
    P_GX    = 5'd16,
    P_GY1   = 5'd17,
    P_GY2   = 5'd18,
    P_GZ1   = 5'd19,
    P_GZ2   = 5'd20,
    P_VX    = 5'd21,
    P_PX    = 5'd22,
    P_VY    = 5'd23,
    P_PY    = 5'd24,
    P_VZ    = 5'd25,
    P_PZ    = 5'd26,
    P_FIN   = 5'd27
  } step_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] r;
    case (idx)
      5'd0:    r = 31'd843314856;
      5'd1:    r = 31'd497837829;
      5'd2:    r = 31'd263043836;
      5'd3:    r = 31'd133525158;
      5'd4:    r = 31'd67021686;
      5'd5:    r = 31'd33543515;
      5'd6:    r = 31'd16775850;
      5'd7:    r = 31'd8388437;
      5'd8:    r = 31'd4194282;
      5'd9:    r = 31'd2097149;
      5'd10:   r = 31'd1048575;
      5'd11:   r = 31'd524287;
      5'd12:   r = 31'd262143;
      5'd13:   r = 31'd131071;
      5'd14:   r = 31'd65535;
      5'd15:   r = 31'd32767;
      5'd16:   r = 31'd16383;
      5'd17:   r = 31'd8191;
      5'd18:   r = 31'd4095;
      5'd19:   r = 31'd2047;
      5'd20:   r = 31'd1023;
      5'd21:   r = 31'd511;
      5'd22:   r = 31'd255;
      5'd23:   r = 31'd127;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sh80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/imu_complementary_filter_dead_reckoning.sv =====
// IMU attitude and dead-reckoning block.
// The input channel (in_valid, in_ready) takes one item: three gyro rates and
// three accelerations, signed Q16.16. The output channel (out_valid, out_ready)
// returns one item per input item: position and roll, pitch and yaw angles.
// The APB port sets the sample period, the blend weight and gravity; write it
// only while the block is idle. pready is always high.
// The bit-serial multiplier works one multiplier bit a cycle over nineteen
// products; four 24-step CORDIC passes, one iteration a cycle, and two
// 14-step angle reductions take the rest of the work. A new item is accepted
// once the previous item's result has reached the output register.
// Reset clears attitude, velocity and position to zero, loads the registers
// with their default values and empties the output register.
// When the receiver stalls, the result waits in the output register; the next
// item is still accepted and computed, and its result waits in the final step
// until the output register is taken.
module imu_complementary_filter_dead_reckoning (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            in_rate_x,
  input  logic signed [31:0]            in_rate_y,
  input  logic signed [31:0]            in_rate_z,
  input  logic signed [31:0]            in_accel_x,
  input  logic signed [31:0]            in_accel_y,
  input  logic signed [31:0]            in_accel_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic signed [31:0]            out_pos_z,
  output logic signed [31:0]            out_roll_angle,
  output logic signed [31:0]            out_pitch_angle,
  output logic signed [31:0]            out_yaw_angle,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imucf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import imucf_pkg::*;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [15:0] dt_r;
  logic [15:0] alpha_r;
  logic [19:0] gm_r;

  logic signed [31:0] rate_x_r, rate_y_r, rate_z_r;
  logic signed [31:0] acc_x_r, acc_y_r, acc_z_r;

  logic signed [31:0] att_r [3];
  logic signed [31:0] att_nxt [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] vel_nxt [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] pos_nxt [3];

  logic signed [21:0] roll_acc_r, roll_acc_nxt, pitch_acc_r, pitch_acc_nxt;
  logic signed [69:0] tmp_r, tmp_nxt;
  logic signed [33:0] cr_r, cr_nxt, sr_r, sr_nxt, cp_r, cp_nxt;
  logic signed [23:0] gx_r, gx_nxt, gy_r, gy_nxt, gz_r, gz_nxt;

  logic signed [69:0] prod_r, prod_nxt;
  logic signed [35:0] mul_a_r, mul_a_nxt;
  logic [33:0]        mul_b_r, mul_b_nxt;
  logic [5:0]         mul_i_r, mul_i_nxt;
  logic               mul_first_r, mul_first_nxt;

  logic signed [55:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [35:0] cz_r, cz_nxt;
  logic [4:0]         cit_r, cit_nxt;
  logic               cord_vec_r, cord_vec_nxt;
  logic               vz_r, vz_nxt;
  logic               rot_neg_r, rot_neg_nxt;

  logic [45:0]        mod_m_r, mod_m_nxt;
  logic [3:0]         mod_k_r, mod_k_nxt;
  logic               mod_neg_r, mod_neg_nxt;
  logic signed [35:0] z_r, z_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_pos_r [3];
  logic signed [31:0] out_att_r [3];
  logic               out_load;

  logic               mul_go;
  logic signed [35:0] mul_a_in;
  logic [33:0]        mul_b_in;
  logic [5:0]         mul_len;

  logic signed [71:0] p16, p30, p30_neg;
  logic signed [23:0] p30_24;
  logic signed [33:0] rmag;
  logic signed [31:0] acc_base;
  logic signed [71:0] sum16;
  logic signed [31:0] sat16;
  logic signed [35:0] g_a;
  logic signed [31:0] blend_sat;
  logic [16:0]        beta;
  logic signed [35:0] net_sel;
  logic signed [69:0] mul_ax, mul_add;

  logic signed [32:0] neg_ax;
  logic signed [55:0] vx_raw, vy_raw, vx_pre, vy_pre;
  logic signed [35:0] vz_pre;
  logic signed [35:0] cz_sh14;
  logic signed [55:0] cx_sh, cy_sh, cx_step, cy_step, rc56, rs56;
  logic signed [35:0] cz_step, at_step;
  logic               cplus;

  logic signed [35:0] m36, z_wrap, z_fold;
  logic               fold_neg;
  logic [45:0]        mod_sub;

  logic [31:0] att32 [3];

  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_SAMPLE_PERIOD: prdata = {16'd0, dt_r};
      REG_BLEND_WEIGHT:  prdata = {16'd0, alpha_r};
      REG_GRAVITY:       prdata = {12'd0, gm_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r    <= SAMPLE_PERIOD_RST;
      alpha_r <= BLEND_WEIGHT_RST;
      gm_r    <= GRAVITY_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SAMPLE_PERIOD: dt_r    <= pwdata[15:0];
        REG_BLEND_WEIGHT:  alpha_r <= pwdata[15:0];
        REG_GRAVITY:       gm_r    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  assign p16     = $signed({{2{prod_r[69]}}, prod_r}) >>> 16;
  assign p30     = $signed({{2{prod_r[69]}}, prod_r}) >>> 30;
  assign p30_neg = -p30;
  assign p30_24  = p30[23:0];
  assign rmag    = p30[33:0];

  always_comb begin
    case (step_r)
      P_VEC1:  acc_base = att_r[2];
      P_GR:    acc_base = att_r[0];
      P_GP:    acc_base = att_r[1];
      P_PX:    acc_base = vel_r[0];
      P_PY:    acc_base = vel_r[1];
      P_PZ:    acc_base = vel_r[2];
      P_VY:    acc_base = pos_r[0];
      P_VZ:    acc_base = pos_r[1];
      P_FIN:   acc_base = pos_r[2];
      default: acc_base = 32'sd0;
    endcase
  end

  assign sum16     = 72'(acc_base) + p16;
  assign sat16     = sat32(sum16);
  assign g_a       = sum16[35:0];
  assign blend_sat = sat32((72'(tmp_r) + 72'(prod_r)) >>> 16);
  assign beta      = 17'h10000 - {1'b0, alpha_r};

  always_comb begin
    case (step_r)
      P_VX:    net_sel = 36'(acc_x_r) - 36'(gx_r);
      P_VY:    net_sel = 36'(acc_y_r) - 36'(gy_r);
      default: net_sel = 36'(acc_z_r) - 36'(gz_r);
    endcase
  end

  assign mul_ax  = 70'(mul_a_r);
  assign mul_add = mul_b_r[mul_i_r] ? (mul_first_r ? -mul_ax : mul_ax) : 70'sd0;

  assign neg_ax = -(33'(acc_x_r));
  assign vx_raw = (step_r == P_VEC1) ? (56'(acc_z_r) <<< 20) : (56'(rmag) <<< 20);
  assign vy_raw = (step_r == P_VEC1) ? (56'(acc_y_r) <<< 20) : (56'(neg_ax) <<< 20);

  always_comb begin
    vx_pre = vx_raw;
    vy_pre = vy_raw;
    vz_pre = 36'sd0;
    if (vx_raw < 0) begin
      if (vy_raw >= 0) begin
        vx_pre = vy_raw;
        vy_pre = -vx_raw;
        vz_pre = HALF_PI_Q30;
      end else begin
        vx_pre = -vy_raw;
        vy_pre = vx_raw;
        vz_pre = -HALF_PI_Q30;
      end
    end
  end

  assign cz_sh14 = cz_r >>> 14;
  assign cx_sh   = cx_r >>> cit_r;
  assign cy_sh   = cy_r >>> cit_r;
  assign at_step = $signed({5'd0, atan_q30(cit_r)});
  assign cplus   = cord_vec_r ? !cy_r[55] : cz_r[35];
  assign cx_step = cplus ? cx_r + cy_sh : cx_r - cy_sh;
  assign cy_step = cplus ? cy_r - cx_sh : cy_r + cx_sh;
  assign cz_step = cplus ? cz_r + at_step : cz_r - at_step;
  assign rc56    = rot_neg_r ? -cx_r : cx_r;
  assign rs56    = rot_neg_r ? -cy_r : cy_r;

  assign m36     = $signed({3'd0, mod_m_r[32:0]});
  assign z_wrap  = (m36 > PI_Q30) ? (mod_neg_r ? TWO_PI_Q30 - m36 : m36 - TWO_PI_Q30)
                                  : (mod_neg_r ? -m36 : m36);
  assign mod_sub = TWO_PI_M << mod_k_r;

  always_comb begin
    z_fold   = z_r;
    fold_neg = 1'b0;
    if (z_r > HALF_PI_Q30) begin
      z_fold   = z_r - PI_Q30;
      fold_neg = 1'b1;
    end else if (z_r < -HALF_PI_Q30) begin
      z_fold   = z_r + PI_Q30;
      fold_neg = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    att_nxt       = att_r;
    vel_nxt       = vel_r;
    pos_nxt       = pos_r;
    roll_acc_nxt  = roll_acc_r;
    pitch_acc_nxt = pitch_acc_r;
    tmp_nxt       = tmp_r;
    cr_nxt        = cr_r;
    sr_nxt        = sr_r;
    cp_nxt        = cp_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    gz_nxt        = gz_r;
    prod_nxt      = prod_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_i_nxt     = mul_i_r;
    mul_first_nxt = mul_first_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    cit_nxt       = cit_r;
    cord_vec_nxt  = cord_vec_r;
    vz_nxt        = vz_r;
    rot_neg_nxt   = rot_neg_r;
    mod_m_nxt     = mod_m_r;
    mod_k_nxt     = mod_k_r;
    mod_neg_nxt   = mod_neg_r;
    z_nxt         = z_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    mul_go        = 1'b0;
    mul_a_in      = 36'sd0;
    mul_b_in      = 34'd0;
    mul_len       = 6'd0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ISSUE;
          step_nxt  = P_YAW;
        end
      end
      S_ISSUE: begin
        step_nxt  = step_t'(step_r + 5'd1);
        state_nxt = S_MUL;
        case (step_r)
          P_YAW: begin
            mul_go = 1'b1; mul_a_in = 36'(rate_z_r);
            mul_b_in = 34'({1'b0, dt_r}); mul_len = LEN_DT;
          end
          P_VEC1, P_VEC2: begin
            if (step_r == P_VEC1) begin
              att_nxt[2] = sat16;
            end
            cx_nxt = vx_pre; cy_nxt = vy_pre; cz_nxt = vz_pre;
            vz_nxt = (vx_raw == 56'sd0) && (vy_raw == 56'sd0);
            cit_nxt = 5'd0; cord_vec_nxt = 1'b1; state_nxt = S_CORD;
          end
          P_MAG: begin
            roll_acc_nxt = vz_r ? 22'sd0 : cz_sh14[21:0];
            mul_go = 1'b1; mul_a_in = cx_r[55:20];
            mul_b_in = GAIN_Q30[33:0]; mul_len = LEN_GAIN;
          end
          P_RX: begin
            pitch_acc_nxt = vz_r ? 22'sd0 : cz_sh14[21:0];
            mul_go = 1'b1; mul_a_in = 36'(rate_x_r);
            mul_b_in = 34'({1'b0, dt_r}); mul_len = LEN_DT;
          end
          P_GR, P_GP: begin
            mul_go = 1'b1; mul_a_in = g_a;
            mul_b_in = 34'({1'b0, alpha_r}); mul_len = LEN_ALPHA;
          end
          P_AR, P_AP: begin
            tmp_nxt = prod_r;
            mul_go = 1'b1;
            mul_a_in = (step_r == P_AR) ? 36'(roll_acc_r) : 36'(pitch_acc_r);
            mul_b_in = 34'(beta); mul_len = LEN_BETA;
          end
          P_RY: begin
            att_nxt[0] = blend_sat;
            mul_go = 1'b1; mul_a_in = 36'(rate_y_r);
            mul_b_in = 34'({1'b0, dt_r}); mul_len = LEN_DT;
          end
          P_MODR, P_MODP: begin
            if (step_r == P_MODR) begin
              att_nxt[1] = blend_sat;
              mod_neg_nxt = att_r[0][31];
              mod_m_nxt = 46'(att32[0]) << 14;
            end else begin
              cr_nxt = rc56[33:0];
              sr_nxt = rs56[33:0];
              mod_neg_nxt = att_r[1][31];
              mod_m_nxt = 46'(att32[1]) << 14;
            end
            mod_k_nxt = 4'(MOD_LAST);
            state_nxt = S_MOD;
          end
          P_WRR, P_WRP: begin
            z_nxt = z_wrap;
            state_nxt = S_ISSUE;
          end
          P_ROTR, P_ROTP: begin
            cx_nxt = 56'(GAIN_Q30); cy_nxt = 56'sd0; cz_nxt = z_fold;
            rot_neg_nxt = fold_neg;
            cit_nxt = 5'd0; cord_vec_nxt = 1'b0; state_nxt = S_CORD;
          end
          P_GX: begin
            cp_nxt = rc56[33:0];
            mul_go = 1'b1; mul_a_in = 36'(rs56);
            mul_b_in = 34'(gm_r); mul_len = LEN_GRAV;
          end
          P_GY1: begin
            gx_nxt = p30_neg[23:0];
            mul_go = 1'b1; mul_a_in = 36'(sr_r);
            mul_b_in = 34'(gm_r); mul_len = LEN_GRAV;
          end
          P_GY2, P_GZ2: begin
            mul_go = 1'b1; mul_a_in = 36'(p30_24);
            mul_b_in = cp_r; mul_len = LEN_TRIG;
          end
          P_GZ1: begin
            gy_nxt = p30_24;
            mul_go = 1'b1; mul_a_in = 36'(cr_r);
            mul_b_in = 34'(gm_r); mul_len = LEN_GRAV;
          end
          P_VX, P_VY, P_VZ: begin
            if (step_r == P_VX) begin
              gz_nxt = p30_24;
            end else if (step_r == P_VY) begin
              pos_nxt[0] = sat16;
            end else begin
              pos_nxt[1] = sat16;
            end
            mul_go = 1'b1; mul_a_in = net_sel;
            mul_b_in = 34'({1'b0, dt_r}); mul_len = LEN_DT;
          end
          P_PX, P_PY, P_PZ: begin
            if (step_r == P_PX) begin
              vel_nxt[0] = sat16;
            end else if (step_r == P_PY) begin
              vel_nxt[1] = sat16;
            end else begin
              vel_nxt[2] = sat16;
            end
            mul_go = 1'b1; mul_a_in = 36'(sat16);
            mul_b_in = 34'({1'b0, dt_r}); mul_len = LEN_DT;
          end
          P_FIN: begin
            pos_nxt[2] = sat16;
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
        if (mul_go) begin
          mul_a_nxt     = mul_a_in;
          mul_b_nxt     = mul_b_in;
          mul_i_nxt     = mul_len - 6'd1;
          mul_first_nxt = 1'b1;
          prod_nxt      = 70'sd0;
        end
      end
      S_MUL: begin
        prod_nxt      = (prod_r <<< 1) + mul_add;
        mul_first_nxt = 1'b0;
        if (mul_i_r == 6'd0) begin
          state_nxt = S_ISSUE;
        end else begin
          mul_i_nxt = mul_i_r - 6'd1;
        end
      end
      S_CORD: begin
        cx_nxt = cx_step;
        cy_nxt = cy_step;
        cz_nxt = cz_step;
        if (cit_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = S_ISSUE;
        end else begin
          cit_nxt = cit_r + 5'd1;
        end
      end
      S_MOD: begin
        if (mod_m_r >= mod_sub) begin
          mod_m_nxt = mod_m_r - mod_sub;
        end
        if (mod_k_r == 4'd0) begin
          state_nxt = S_ISSUE;
        end else begin
          mod_k_nxt = mod_k_r - 4'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      att32[i] = att_r[i][31] ? 32'(-(33'(att_r[i]))) : 32'(att_r[i]);
    end
    att32[2] = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= P_YAW;
      out_valid_r <= 1'b0;
      mul_i_r     <= 6'd0;
      cit_r       <= 5'd0;
      mod_k_r     <= 4'd0;
      for (int i = 0; i < 3; i++) begin
        att_r[i] <= 32'sd0;
        vel_r[i] <= 32'sd0;
        pos_r[i] <= 32'sd0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      mul_i_r     <= mul_i_nxt;
      cit_r       <= cit_nxt;
      mod_k_r     <= mod_k_nxt;
      att_r       <= att_nxt;
      vel_r       <= vel_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rate_x_r <= in_rate_x;
      rate_y_r <= in_rate_y;
      rate_z_r <= in_rate_z;
      acc_x_r  <= in_accel_x;
      acc_y_r  <= in_accel_y;
      acc_z_r  <= in_accel_z;
    end
    if (out_load) begin
      out_pos_r <= pos_r;
      out_att_r <= att_r;
    end
    roll_acc_r  <= roll_acc_nxt;
    pitch_acc_r <= pitch_acc_nxt;
    tmp_r       <= tmp_nxt;
    cr_r        <= cr_nxt;
    sr_r        <= sr_nxt;
    cp_r        <= cp_nxt;
    gx_r        <= gx_nxt;
    gy_r        <= gy_nxt;
    gz_r        <= gz_nxt;
    prod_r      <= prod_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    mul_first_r <= mul_first_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    cord_vec_r  <= cord_vec_nxt;
    vz_r        <= vz_nxt;
    rot_neg_r   <= rot_neg_nxt;
    mod_m_r     <= mod_m_nxt;
    mod_neg_r   <= mod_neg_nxt;
    z_r         <= z_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = out_pos_r[0];
  assign out_pos_y       = out_pos_r[1];
  assign out_pos_z       = out_pos_r[2];
  assign out_roll_angle  = out_att_r[0];
  assign out_pitch_angle = out_att_r[1];
  assign out_yaw_angle   = out_att_r[2];

`include "imu_complementary_filter_dead_reckoning_macros.svh"

  `IMUCF_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == S_ISSUE && step_r == P_YAW)
  `IMUCF_ASSERT_NEXT(a_done_fills_out, clk, rst_n, state_r == S_DONE, out_valid_r)
  `IMUCF_ASSERT_SAME(a_cordic_count, clk, rst_n, state_r == S_CORD, cit_r <= 5'(CORDIC_STEPS - 1))
  `IMUCF_ASSERT_SAME(a_mul_count, clk, rst_n, state_r == S_MUL, mul_i_r <= (LEN_TRIG - 6'd1))

endmodule

// ===== sim/imucf_checker.sv =====
module imucf_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [31:0]            in_rate_x,
  input  logic signed [31:0]            in_rate_y,
  input  logic signed [31:0]            in_rate_z,
  input  logic signed [31:0]            in_accel_x,
  input  logic signed [31:0]            in_accel_y,
  input  logic signed [31:0]            in_accel_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [31:0]            out_pos_x,
  input  logic signed [31:0]            out_pos_y,
  input  logic signed [31:0]            out_pos_z,
  input  logic signed [31:0]            out_roll_angle,
  input  logic signed [31:0]            out_pitch_angle,
  input  logic signed [31:0]            out_yaw_angle,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [imucf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output int                            fail_count,
  output int                            backlog
);
  import imucf_pkg::*;

  typedef struct {
    logic signed [31:0] pos[3];
    logic signed [31:0] ang[3];
  } fix_t;

  localparam longint GAIN = 64'sd652032874;
  localparam longint PI_Q = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint TWO_PI_Q = 64'sd6746518852;
  localparam longint ARCTAN [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127
  };

  logic [15:0] dt_reg;
  logic [15:0] alpha_reg;
  logic [19:0] grav_reg;
  logic signed [31:0] att[3];
  logic signed [31:0] vel[3];
  logic signed [31:0] pos[3];
  fix_t expected_fixes[$];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic tilt_vector(input longint yi, input longint xi, output longint ang,
                             output longint mag);
    longint x, y, z, xn, yn, t;
    z = 0;
    if (xi == 0 && yi == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    x = xi * 1048576;
    y = yi * 1048576;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q;
      end
    end
    for (int i = 0; i < 24; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z += ARCTAN[i];
      end else begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z -= ARCTAN[i];
      end
      x = xn;
      y = yn;
    end
    ang = z >>> 14;
    mag = ((x >>> 20) * GAIN) >>> 30;
  endtask

  task automatic rotate_angle(input longint a, output longint c, output longint s);
    longint z, x, y, xn, yn;
    bit flip;
    z = (a * 16384) % TWO_PI_Q;
    x = GAIN;
    y = 0;
    flip = 0;
    if (z > PI_Q) z -= TWO_PI_Q;
    if (z < -PI_Q) z += TWO_PI_Q;
    if (z > HALF_PI_Q) begin
      z -= PI_Q;
      flip = 1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = xn;
      y = yn;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [31:0] fuse(input logic signed [31:0] angle,
                                             input longint rate, input longint acc_ang);
    longint g, a;
    g = longint'(angle) + ((rate * longint'(dt_reg)) >>> 16);
    a = longint'(alpha_reg);
    return clamp32((a * g + (65536 - a) * acc_ang) >>> 16);
  endfunction

  task automatic predict_fix(input longint rate[3], input longint acc[3]);
    longint dt, gm, roll_acc, pitch_acc, r, unused, cr, sr, cp, sp, net;
    longint grav[3];
    fix_t f;
    dt = longint'(dt_reg);
    gm = longint'(grav_reg);
    att[2] = clamp32(longint'(att[2]) + ((rate[2] * dt) >>> 16));
    tilt_vector(acc[1], acc[2], roll_acc, r);
    tilt_vector(-acc[0], r, pitch_acc, unused);
    att[0] = fuse(att[0], rate[0], roll_acc);
    att[1] = fuse(att[1], rate[1], pitch_acc);
    rotate_angle(longint'(att[0]), cr, sr);
    rotate_angle(longint'(att[1]), cp, sp);
    grav[0] = -((gm * sp) >>> 30);
    grav[1] = (((gm * sr) >>> 30) * cp) >>> 30;
    grav[2] = (((gm * cr) >>> 30) * cp) >>> 30;
    for (int i = 0; i < 3; i++) begin
      net = acc[i] - grav[i];
      vel[i] = clamp32(longint'(vel[i]) + ((net * dt) >>> 16));
      pos[i] = clamp32(longint'(pos[i]) + ((longint'(vel[i]) * dt) >>> 16));
      f.pos[i] = pos[i];
      f.ang[i] = att[i];
    end
    expected_fixes.push_back(f);
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign backlog = expected_fixes.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    longint rate[3];
    longint acc[3];
    fix_t f;
    if (!rst_n) begin
      dt_reg <= SAMPLE_PERIOD_RST;
      alpha_reg <= BLEND_WEIGHT_RST;
      grav_reg <= GRAVITY_RST;
      for (int i = 0; i < 3; i++) begin
        att[i] = 0;
        vel[i] = 0;
        pos[i] = 0;
      end
      expected_fixes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SAMPLE_PERIOD: dt_reg <= pwdata[15:0];
          REG_BLEND_WEIGHT:  alpha_reg <= pwdata[15:0];
          REG_GRAVITY:       grav_reg <= pwdata[19:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        rate[0] = in_rate_x;
        rate[1] = in_rate_y;
        rate[2] = in_rate_z;
        acc[0] = in_accel_x;
        acc[1] = in_accel_y;
        acc[2] = in_accel_z;
        predict_fix(rate, acc);
      end
      if (out_valid && out_ready) begin
        if (expected_fixes.size() == 0) begin
          $error("result item arrived with none expected");
          fail_count++;
        end else begin
          f = expected_fixes.pop_front();
          compare_field("pos_x", f.pos[0], out_pos_x);
          compare_field("pos_y", f.pos[1], out_pos_y);
          compare_field("pos_z", f.pos[2], out_pos_z);
          compare_field("roll_angle", f.ang[0], out_roll_angle);
          compare_field("pitch_angle", f.ang[1], out_pitch_angle);
          compare_field("yaw_angle", f.ang[2], out_yaw_angle);
        end
      end
    end
  end
endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import imucf_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE = 600;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    logic signed [31:0] rate[3];
    logic signed [31:0] acc[3];
  } sample_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] in_rate_x, in_rate_y, in_rate_z;
  logic signed [31:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_roll_angle, out_pitch_angle, out_yaw_angle;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, backlog;
  int cycles;
  int samples_sent;
  int settings_used;
  int hold;

  imu_complementary_filter_dead_reckoning uut (.*);

  imucf_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b1;
          hold <= $urandom_range(1, 2000);
        end
        1: begin
          out_ready <= 1'b0;
          hold <= $urandom_range(1, 700);
        end
        2: begin
          out_ready <= 1'b0;
          hold <= $urandom_range(1, 5);
        end
        default: begin
          out_ready <= 1'b1;
          hold <= $urandom_range(1, 5);
        end
      endcase
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_sample(input sample_t s);
    in_valid <= 1'b1;
    in_rate_x <= s.rate[0];
    in_rate_y <= s.rate[1];
    in_rate_z <= s.rate[2];
    in_accel_x <= s.acc[0];
    in_accel_y <= s.acc[1];
    in_accel_z <= s.acc[2];
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    pause_input(1);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value(input bit is_rate);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return 0;
      default: begin
        if (is_rate) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      end
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    for (int i = 0; i < 3; i++) begin
      s.rate[i] = pick_value(1);
      s.acc[i] = pick_value(0);
    end
    if ($urandom_range(0, 4) == 0) begin
      s.acc[0] = 0;
      s.acc[1] = 0;
      s.acc[2] = $urandom_range(0, 3) == 0 ? 0 : 642689;
      if ($urandom_range(0, 1)) s.acc[0] = pick_value(0);
    end
    return s;
  endfunction

  function automatic sample_t uniform_sample(input logic signed [31:0] r,
                                             input logic signed [31:0] a);
    sample_t s;
    for (int i = 0; i < 3; i++) begin
      s.rate[i] = r;
      s.acc[i] = a;
    end
    return s;
  endfunction

  task automatic random_phase(input int n);
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        pause_input($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
      end
      send_sample(random_sample());
      burst--;
    end
    drain();
  endtask

  initial begin
    sample_t s;
    rst_n = 0;
    in_valid = 0;
    in_rate_x = 0;
    in_rate_y = 0;
    in_rate_z = 0;
    in_accel_x = 0;
    in_accel_y = 0;
    in_accel_z = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    samples_sent = 0;
    settings_used = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(uniform_sample(0, 0));
    send_sample(uniform_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_sample(uniform_sample(32'sh80000000, 32'sh80000000));
    send_sample(uniform_sample(32'sh7FFFFFFF, 32'sh80000000));
    send_sample(uniform_sample(32'sh80000000, 32'sh7FFFFFFF));
    s = uniform_sample(0, 0);
    s.acc[0] = 65536;
    send_sample(s);
    s.acc[0] = -65536;
    send_sample(s);
    s.acc[0] = 32'sh80000000;
    send_sample(s);
    s = uniform_sample(65536, 0);
    s.acc[2] = 642689;
    send_sample(s);
    s.acc[1] = -642689;
    s.acc[2] = -1;
    send_sample(s);
    s = uniform_sample(-1, -1);
    send_sample(s);
    drain();

    write_reg(REG_SAMPLE_PERIOD, 32'hFFFF);
    write_reg(REG_BLEND_WEIGHT, 32'hFFFF);
    write_reg(REG_GRAVITY, 32'hFFFFF);
    write_reg(REG_SPARE, 32'hFFFFFFFF);
    settings_used++;
    send_sample(uniform_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_sample(uniform_sample(32'sh80000000, 32'sh80000000));
    random_phase(100);

    write_reg(REG_SAMPLE_PERIOD, 0);
    write_reg(REG_BLEND_WEIGHT, 0);
    write_reg(REG_GRAVITY, 0);
    settings_used++;
    random_phase(80);

    write_reg(REG_SAMPLE_PERIOD, 655);
    write_reg(REG_BLEND_WEIGHT, 64225);
    write_reg(REG_GRAVITY, 642689);
    settings_used++;
    random_phase(250);

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_SAMPLE_PERIOD, $urandom_range(0, 65535));
      write_reg(REG_BLEND_WEIGHT, $urandom_range(0, 65535));
      write_reg(REG_GRAVITY, $urandom_range(0, 1048575));
      settings_used++;
      random_phase(90);
    end

    $display("Run covered %0d samples under %0d register settings, extremes included.",
             samples_sent, settings_used);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/imucf_pkg.sv
rtl/core/imu_complementary_filter_dead_reckoning.sv
sim/imucf_checker.sv
sim/tb_top.sv
